FILE: rtl/idab_pkg.sv
`timescale 1ns / 1ps
package idab_pkg;

   localparam int ID_BITS_DEF   = 12;
   localparam int MAP_WORDS_DEF = 64;
   localparam int WORD_W        = 64;
   localparam int WORD_AW       = 6;

   localparam logic [1:0] KIND_ALLOC   = 2'd0;
   localparam logic [1:0] KIND_FREE    = 2'd1;
   localparam logic [1:0] KIND_RESERVE = 2'd2;
   localparam logic [1:0] KIND_CLEAR   = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_RANGE     = 3'd1;
   localparam logic [2:0] ST_FREE      = 3'd2;
   localparam logic [2:0] ST_INUSE     = 3'd3;
   localparam logic [2:0] ST_EXHAUSTED = 3'd4;

   // Position of the lowest set bit, found by halving the word six times.
   function automatic logic [WORD_AW-1:0] first_set(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0]  w;
      logic [WORD_AW-1:0] p;
      logic [WORD_W-1:0]  low;
      w = v;
      p = '0;
      for (int lvl = WORD_AW - 1; lvl >= 0; lvl--) begin
         low = (WORD_W'(1) << (1 << lvl)) - WORD_W'(1);
         if ((w & low) == '0) begin
            p[lvl] = 1'b1;
            w = w >> (1 << lvl);
         end
      end
      return p;
   endfunction

endpackage

FILE: rtl/id_allocator_bitmap_free_stack.sv
`timescale 1ns / 1ps
// One request at a time. Free and reserve do a read-modify-write of the bitmap word, skipped
// when the ID is out of range; allocate pops the stack, discarding each stale entry, or else
// reads the counter's bitmap word, moving past each word with no free ID, until it finds an
// ID or the ID space is exhausted. The response waits until the output register is free.
// Clear sweeps the whole map (64 words by default) to zero.
// After reset the bitmap is swept to zero over one cycle per word before a request is taken.
module id_allocator_bitmap_free_stack #(
   parameter int ID_BITS   = idab_pkg::ID_BITS_DEF,
   parameter int MAP_WORDS = idab_pkg::MAP_WORDS_DEF,
   localparam int RSP_W    = ((ID_BITS + 3 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [15:0]      req_tdata,   // request_id
   input  logic [1:0]       req_tuser,   // kind
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // granted_id, status, zero fill
);
   import idab_pkg::*;

   localparam int LIM_BITS = 1 << ID_BITS;
   localparam int LIM_MAP  = MAP_WORDS * WORD_W;
   localparam int ID_SPACE = (LIM_BITS < LIM_MAP) ? LIM_BITS : LIM_MAP;
   localparam int MAP_DEPTH = ID_SPACE / WORD_W;
   localparam int ID_AW    = $clog2(ID_SPACE);
   localparam int MAP_AW   = ID_AW - WORD_AW;
   localparam int CW       = ID_AW + 1;

   localparam logic [3:0] S_INIT     = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_CLEAR    = 4'd2;
   localparam logic [3:0] S_MAPCHK   = 4'd3;
   localparam logic [3:0] S_ALLOC    = 4'd4;
   localparam logic [3:0] S_POPWAIT  = 4'd5;
   localparam logic [3:0] S_POPCHK   = 4'd6;
   localparam logic [3:0] S_FRESHCHK = 4'd7;
   localparam logic [3:0] S_OUT      = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [1:0]        kind_ff, kind_in;
   logic [ID_AW-1:0]  id_ff, id_in;
   logic [ID_AW-1:0]  res_id_ff, res_id_in;
   logic [2:0]        res_st_ff, res_st_in;
   logic [CW-1:0]     fresh_ff, fresh_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_BITS-1:0] rsp_id_ff, rsp_id_in;
   logic [2:0]        rsp_st_ff, rsp_st_in;

   logic              map_clear, map_busy, map_rd, map_wr;
   logic [MAP_AW-1:0] map_addr;
   logic [WORD_W-1:0] map_wdata, map_rdata;
   logic              stk_clear, stk_push, stk_pop, stk_empty;
   logic [ID_AW-1:0]  stk_pop_id;

   logic              accept, out_range, bit_id, bit_pop;
   logic [WORD_W-1:0] fresh_free;
   logic [WORD_AW-1:0] fresh_pos;
   logic [ID_AW-1:0]  fresh_id;

   idab_bitmap #(.DEPTH(MAP_DEPTH)) u_bitmap (
      .clock       (clock),
      .reset       (reset),
      .clear_start (map_clear),
      .busy        (map_busy),
      .rd_en       (map_rd),
      .wr_en       (map_wr),
      .addr        (map_addr),
      .wr_data     (map_wdata),
      .rd_data     (map_rdata)
   );

   idab_stack #(.DEPTH(ID_SPACE)) u_stack (
      .clock   (clock),
      .reset   (reset),
      .clear   (stk_clear),
      .push    (stk_push),
      .pop     (stk_pop),
      .push_id (id_ff),
      .empty   (stk_empty),
      .pop_id  (stk_pop_id)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_range  = ({1'b0, req_tdata} >= 17'(ID_SPACE));
   assign bit_id     = map_rdata[id_ff[WORD_AW-1:0]];
   assign bit_pop    = map_rdata[stk_pop_id[WORD_AW-1:0]];

   // Free IDs in the counter's word at or above the counter.
   assign fresh_free = ~map_rdata & ({WORD_W{1'b1}} << fresh_ff[WORD_AW-1:0]);
   assign fresh_pos  = first_set(fresh_free);
   assign fresh_id   = {fresh_ff[ID_AW-1:WORD_AW], fresh_pos};

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      id_in     = id_ff;
      res_id_in = res_id_ff;
      res_st_in = res_st_ff;
      fresh_in  = fresh_ff;
      map_clear = 1'b0;
      map_rd    = 1'b0;
      map_wr    = 1'b0;
      map_addr  = id_ff[ID_AW-1:WORD_AW];
      map_wdata = map_rdata;
      stk_clear = 1'b0;
      stk_push  = 1'b0;
      stk_pop   = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            if (!map_busy) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               kind_in   = req_tuser;
               id_in     = req_tdata[ID_AW-1:0];
               res_id_in = '0;
               res_st_in = ST_OK;
               unique case (req_tuser)
                  KIND_ALLOC: begin
                     state_in = S_ALLOC;
                  end
                  KIND_CLEAR: begin
                     map_clear = 1'b1;
                     stk_clear = 1'b1;
                     fresh_in  = CW'(1);
                     state_in  = S_CLEAR;
                  end
                  default: begin
                     if (out_range) begin
                        res_st_in = ST_RANGE;
                        state_in  = S_OUT;
                     end else begin
                        map_rd   = 1'b1;
                        map_addr = req_tdata[ID_AW-1:WORD_AW];
                        state_in = S_MAPCHK;
                     end
                  end
               endcase
            end
         end
         S_CLEAR: begin
            if (!map_busy) begin
               state_in = S_OUT;
            end
         end
         S_MAPCHK: begin
            state_in = S_OUT;
            if (kind_ff == KIND_FREE) begin
               if (!bit_id) begin
                  res_st_in = ST_FREE;
               end else begin
                  map_wr    = 1'b1;
                  map_wdata = map_rdata & ~(WORD_W'(1) << id_ff[WORD_AW-1:0]);
                  stk_push  = 1'b1;
               end
            end else begin
               if (bit_id) begin
                  res_st_in = ST_INUSE;
               end else begin
                  map_wr    = 1'b1;
                  map_wdata = map_rdata | (WORD_W'(1) << id_ff[WORD_AW-1:0]);
               end
            end
         end
         S_ALLOC: begin
            if (!stk_empty) begin
               stk_pop  = 1'b1;
               state_in = S_POPWAIT;
            end else if (fresh_ff == CW'(ID_SPACE)) begin
               res_st_in = ST_EXHAUSTED;
               state_in  = S_OUT;
            end else begin
               map_rd   = 1'b1;
               map_addr = fresh_ff[ID_AW-1:WORD_AW];
               state_in = S_FRESHCHK;
            end
         end
         S_POPWAIT: begin
            map_rd   = 1'b1;
            map_addr = stk_pop_id[ID_AW-1:WORD_AW];
            state_in = S_POPCHK;
         end
         S_POPCHK: begin
            map_addr = stk_pop_id[ID_AW-1:WORD_AW];
            // An entry reserved again since it was freed is dropped.
            if (bit_pop) begin
               state_in = S_ALLOC;
            end else begin
               map_wr    = 1'b1;
               map_wdata = map_rdata | (WORD_W'(1) << stk_pop_id[WORD_AW-1:0]);
               res_id_in = stk_pop_id;
               state_in  = S_OUT;
            end
         end
         S_FRESHCHK: begin
            map_addr = fresh_ff[ID_AW-1:WORD_AW];
            if (fresh_free != '0) begin
               map_wr    = 1'b1;
               map_wdata = map_rdata | (WORD_W'(1) << fresh_pos);
               res_id_in = fresh_id;
               fresh_in  = CW'(fresh_id) + 1'b1;
               state_in  = S_OUT;
            end else begin
               fresh_in = {fresh_ff[CW-1:WORD_AW] + 1'b1, {WORD_AW{1'b0}}};
               state_in = S_ALLOC;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_st_in    = rsp_st_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = ID_BITS'(res_id_ff);
         rsp_st_in    = res_st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         fresh_ff     <= CW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      id_ff     <= id_in;
      res_id_ff <= res_id_in;
      res_st_ff <= res_st_in;
      rsp_id_ff <= rsp_id_in;
      rsp_st_ff <= rsp_st_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_st_ff, rsp_id_ff});

endmodule

FILE: rtl/idab_bitmap.sv
`timescale 1ns / 1ps
module idab_bitmap #(
   parameter int DEPTH = idab_pkg::MAP_WORDS_DEF,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear_start,
   output logic                       busy,
   input  logic                       rd_en,
   input  logic                       wr_en,
   input  logic [AW-1:0]              addr,
   input  logic [idab_pkg::WORD_W-1:0] wr_data,
   output logic [idab_pkg::WORD_W-1:0] rd_data
);
   import idab_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;
   logic              sweep_ff, sweep_in;
   logic [AW-1:0]     sweep_addr_ff, sweep_addr_in;

   // The sweep writes one zero word per cycle after reset and on a clear.
   always_comb begin
      sweep_in      = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      if (clear_start) begin
         sweep_in      = 1'b1;
         sweep_addr_in = '0;
      end else if (sweep_ff) begin
         sweep_addr_in = sweep_addr_ff + 1'b1;
         if (sweep_addr_ff == AW'(DEPTH - 1)) begin
            sweep_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
      end else begin
         sweep_ff      <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sweep_ff) begin
         mem[sweep_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign busy    = sweep_ff;
   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/idab_stack.sv
`timescale 1ns / 1ps
module idab_stack #(
   parameter int DEPTH = 1 << idab_pkg::ID_BITS_DEF,
   localparam int AW   = $clog2(DEPTH),
   localparam int CW   = AW + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          clear,
   input  logic          push,
   input  logic          pop,
   input  logic [AW-1:0] push_id,
   output logic          empty,
   output logic [AW-1:0] pop_id
);
   import idab_pkg::*;

   logic [AW-1:0] mem [DEPTH];
   logic [AW-1:0] pop_id_ff;
   logic [CW-1:0] count_ff, count_in;
   logic          full;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   // A push onto a full stack is dropped; the ID is simply not recycled.
   always_comb begin
      count_in = count_ff;
      if (clear) begin
         count_in = '0;
      end else if (push && !full) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !empty) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem[count_ff[AW-1:0]] <= push_id;
      end
      if (pop && !empty) begin
         pop_id_ff <= mem[AW'(count_ff - 1'b1)];
      end
   end

   assign pop_id = pop_id_ff;

endmodule

FILE: tb/sv/tb_id_allocator_bitmap_free_stack.sv
`timescale 1ns / 1ps
module tb_id_allocator_bitmap_free_stack;
   import idab_pkg::*;

   localparam int ID_BITS   = ID_BITS_DEF;
   localparam int MAP_WORDS = MAP_WORDS_DEF;
   localparam int RSP_W     = ((ID_BITS + 3 + 7) / 8) * 8;
   localparam int ID_SPACE  = ((1 << ID_BITS) < MAP_WORDS * 64) ? (1 << ID_BITS)
                                                                : MAP_WORDS * 64;

   typedef struct packed {
      logic [ID_BITS-1:0] granted;
      logic [2:0]         status;
   } outcome_type;

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [15:0]      req_tdata  = '0;   // request_id
   logic [1:0]       req_tuser  = '0;   // kind
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;         // granted_id, status, zero fill

   id_allocator_bitmap_free_stack dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Allocator state as the block should hold it.
   bit [ID_SPACE-1:0]  id_busy;
   logic [ID_BITS-1:0] freed_stack [ID_SPACE];
   int                 stack_depth = 0;
   int                 fresh_next  = 1;

   outcome_type        pending_outcomes [$];
   logic [ID_BITS-1:0] live_ids [$];
   logic [15:0]        last_freed   = '0;
   int                 mismatch_count = 0;
   bit                 idle_enabled = 1'b1;
   int                 hold_left    = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #12_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic outcome_type apply_request(input logic [1:0] kind, input logic [15:0] id);
      outcome_type        o;
      logic [ID_BITS-1:0] cand;
      bit                 found;
      o.granted = '0;
      o.status  = ST_OK;
      found     = 1'b0;
      case (kind)
         KIND_ALLOC: begin
            // Stacked IDs that were reserved again after being freed are dropped.
            while (stack_depth > 0 && !found) begin
               stack_depth--;
               cand = freed_stack[stack_depth];
               if (!id_busy[cand]) begin
                  found         = 1'b1;
                  id_busy[cand] = 1'b1;
                  o.granted     = cand;
               end
            end
            if (!found) begin
               while (fresh_next < ID_SPACE && id_busy[fresh_next]) fresh_next++;
               if (fresh_next >= ID_SPACE) begin
                  o.status = ST_EXHAUSTED;
               end else begin
                  id_busy[fresh_next] = 1'b1;
                  o.granted           = ID_BITS'(fresh_next);
                  fresh_next++;
               end
            end
         end
         KIND_FREE: begin
            if (int'(id) >= ID_SPACE) begin
               o.status = ST_RANGE;
            end else if (!id_busy[id]) begin
               o.status = ST_FREE;
            end else begin
               id_busy[id] = 1'b0;
               // A full stack loses the ID; it stays free in the map.
               if (stack_depth < ID_SPACE) begin
                  freed_stack[stack_depth] = ID_BITS'(id);
                  stack_depth++;
               end
            end
         end
         KIND_RESERVE: begin
            if (int'(id) >= ID_SPACE) o.status = ST_RANGE;
            else if (id_busy[id]) o.status = ST_INUSE;
            else id_busy[id] = 1'b1;
         end
         default: begin
            id_busy     = '0;
            stack_depth = 0;
            fresh_next  = 1;
         end
      endcase
      return o;
   endfunction

   task automatic send_request(input logic [1:0] kind, input logic [15:0] id,
                               output outcome_type o);
      int gap;
      gap = idle_enabled ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= id;
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      o = apply_request(kind, id);
      pending_outcomes.push_back(o);
      if (kind == KIND_CLEAR) begin
         live_ids.delete();
      end else if (o.status == ST_OK) begin
         case (kind)
            KIND_ALLOC:   live_ids.push_back(o.granted);
            KIND_RESERVE: live_ids.push_back(ID_BITS'(id));
            default: begin
               last_freed = id;
               for (int i = 0; i < live_ids.size(); i++) begin
                  if (live_ids[i] == ID_BITS'(id)) begin
                     live_ids.delete(i);
                     break;
                  end
               end
            end
         endcase
      end
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_outcomes.size() != 0);
   endtask

   // Receiver: random stalls, plus a long hold-off when a test asks for one.
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!idle_enabled || $urandom_range(99) < 70) begin
            rsp_tready <= 1'b1;
         end else begin
            stall_left = pick_gap();
            rsp_tready <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            $error("unexpected transfer: granted_id %0d status %0d",
                   rsp_tdata[ID_BITS-1:0], rsp_tdata[ID_BITS+2:ID_BITS]);
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_tdata[ID_BITS-1:0] !== want.granted) begin
               $error("granted_id: expected %0d, actual %0d", want.granted,
                      rsp_tdata[ID_BITS-1:0]);
               mismatch_count++;
            end
            if (rsp_tdata[ID_BITS+2:ID_BITS] !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status,
                      rsp_tdata[ID_BITS+2:ID_BITS]);
               mismatch_count++;
            end
         end
      end
   end

   task automatic test_directed();
      outcome_type o;
      idle_enabled = 1'b1;
      send_request(KIND_ALLOC,   16'h0000, o);
      send_request(KIND_ALLOC,   16'hFFFF, o);
      send_request(KIND_FREE,    16'd1,    o);
      send_request(KIND_FREE,    16'd1,    o);
      send_request(KIND_FREE,    16'd4096, o);
      send_request(KIND_FREE,    16'hFFFF, o);
      send_request(KIND_RESERVE, 16'd0,    o);
      send_request(KIND_RESERVE, 16'd2,    o);
      send_request(KIND_RESERVE, 16'h8000, o);
      send_request(KIND_RESERVE, 16'd4095, o);
      send_request(KIND_ALLOC,   16'h1234, o);
      // ID zero goes through the stack and comes back out like any other.
      send_request(KIND_FREE,    16'd0,    o);
      send_request(KIND_ALLOC,   16'h0000, o);
      send_request(KIND_FREE,    16'd2,    o);
      send_request(KIND_RESERVE, 16'd2,    o);
      send_request(KIND_ALLOC,   16'hAAAA, o);
      send_request(KIND_FREE,    16'd4095, o);
      send_request(KIND_ALLOC,   16'h5555, o);
      send_request(KIND_CLEAR,   16'h5A5A, o);
      send_request(KIND_ALLOC,   16'h0000, o);
      send_request(KIND_FREE,    16'd1,    o);
      send_request(KIND_RESERVE, 16'd1,    o);
      wait_for_results();
   endtask

   // Runs the fresh counter across a whole reserved word and past a single reserved ID.
   task automatic test_fresh_scan();
      outcome_type o;
      idle_enabled = 1'b0;
      send_request(KIND_CLEAR, 16'hFFFF, o);
      for (int i = 64; i < 128; i++) send_request(KIND_RESERVE, 16'(i), o);
      send_request(KIND_RESERVE, 16'd300, o);
      for (int i = 0; i < 250; i++) send_request(KIND_ALLOC, 16'($urandom), o);
      wait_for_results();
   endtask

   // Stacks stale entries, which the next allocate discards one after another.
   task automatic test_stale_entries();
      outcome_type o;
      idle_enabled = 1'b0;
      for (int i = 0; i < 64; i++) begin
         send_request(KIND_FREE,    16'd5, o);
         send_request(KIND_RESERVE, 16'd5, o);
      end
      send_request(KIND_ALLOC,   16'd0, o);
      send_request(KIND_FREE,    16'd7, o);
      send_request(KIND_ALLOC,   16'd0, o);
      send_request(KIND_RESERVE, 16'd7, o);
      send_request(KIND_FREE,    16'd7, o);
      send_request(KIND_ALLOC,   16'd0, o);
      send_request(KIND_CLEAR,   16'd0, o);
      wait_for_results();
   endtask

   task automatic test_backpressure();
      outcome_type o;
      idle_enabled = 1'b0;
      hold_left    = 300;
      for (int i = 0; i < 24; i++) begin
         if (i % 2 == 0) send_request(KIND_ALLOC, 16'($urandom), o);
         else send_request(KIND_FREE, 16'(o.granted), o);
      end
      wait_for_results();
   endtask

   task automatic test_random(input int count);
      outcome_type o;
      logic [1:0]  kind;
      logic [15:0] id;
      int          r;
      int          s;
      for (int i = 0; i < count; i++) begin
         if (i % 150 == 0) idle_enabled = ($urandom_range(3) != 0);
         r  = $urandom_range(999);
         s  = $urandom_range(99);
         id = 16'($urandom);
         if (r < 400) begin
            kind = KIND_ALLOC;
         end else if (r < 700) begin
            kind = KIND_FREE;
            if (s < 65 && live_ids.size() > 0)
               id = 16'(live_ids[$urandom_range(live_ids.size() - 1)]);
            else if (s < 80) id = 16'($urandom_range(63));
            else if (s < 90) id = 16'($urandom_range(ID_SPACE - 1));
         end else if (r < 985) begin
            kind = KIND_RESERVE;
            // Reserving a recently freed ID leaves a stale entry on the stack.
            if (s < 20) id = last_freed;
            else if (s < 55) id = 16'($urandom_range(127));
            else if (s < 70 && live_ids.size() > 0)
               id = 16'(live_ids[$urandom_range(live_ids.size() - 1)]);
            else if (s < 85) id = 16'($urandom_range(ID_SPACE - 1));
         end else begin
            kind = KIND_CLEAR;
         end
         send_request(kind, id, o);
      end
      idle_enabled = 1'b1;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fresh_scan();
      test_stale_entries();
      test_backpressure();
      test_random(1350);
      wait_for_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/idab_pkg.sv
rtl/idab_bitmap.sv
rtl/idab_stack.sv
rtl/id_allocator_bitmap_free_stack.sv
tb/sv/tb_id_allocator_bitmap_free_stack.sv
